>>> rtl/core/ssfw_pkg.sv
// Shared types and constants for the sample stream framer.
// Holds the control word layout used by the sequencer and the datapath.
`default_nettype none

package ssfw_pkg;

    localparam int StepW = 4;

    localparam logic [7:0]  SyncByte  = 8'hBB;
    localparam logic [15:0] FailSat   = 16'hFFFF;
    localparam logic [15:0] WarnReset = 16'd10;
    localparam logic [15:0] StopReset = 16'd50;

    // Register selects, compared against paddr[2]
    localparam logic RegWarn = 1'b0;
    localparam logic RegStop = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_WARN  = 2'd1,
        EV_STUCK = 2'd2,
        EV_NOCH  = 2'd3
    } t_ev;

    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_SYNC,
        SRC_MASK,
        SRC_LEN,
        SRC_HI,
        SRC_LO,
        SRC_SUM
    } t_src;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NOIN,
        C_EMPTY,
        C_STOP,
        C_MORE
    } t_cond;

    typedef struct packed {
        logic             load;
        logic             upd;
        logic             emit;
        t_src             src;
        t_ev              ev;
        logic             ev_dyn;
        logic             last;
        t_cond            cond;
        logic [StepW-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic empty;
        logic stop;
        logic more;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/core/sample_stream_framer_with_fault_watch_top.sv
// Sample set framer with consecutive-failure watch: top level.
// Holds the register port; instantiates ssfw_seq and ssfw_dp, uses ssfw_pkg.
//
// Usage:
//   The slave channel takes one sample set per item. The master channel gives
//   one frame byte per item: sync, mask, length, high/low byte per set channel,
//   XOR checksum; tlast marks the final byte, tuser carries the fault event.
//   An empty mask or a reached stop threshold yields a single event item.
//   A set is taken only when the sequencer waits at its first step, so one
//   set is in work at a time. After accept the sequencer checks the mask,
//   then updates the failure counter, then emits the sync byte; later bytes
//   follow one per cycle while the receiver takes them, paced by the single
//   output register.
//   When the receiver stalls, the output register holds its byte and the
//   sequencer holds its step until the byte is taken.
//   Reset clears the failure counter, the warning flag and the output valid,
//   and loads the thresholds with 10 (warn) and 50 (stop).
//   Registers: warn threshold at 0x0, stop threshold at 0x4, 16 bits each.
`default_nettype none

module sample_stream_framer_with_fault_watch_top #(
    parameter int CHANNELS = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // tdata: channel_mask[7:0], sample_0..sample_7 (16 bits each, from bit 8),
    //        failed_reads[139:136], channels_read[143:140]
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: frame_byte[7:0]
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    // tuser: fault_event[1:0]
    output logic [1:0]        m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0] r_warn;
    logic [15:0] r_stop;

    ssfw_pkg::t_ctrl ctrl;
    ssfw_pkg::t_stat stat;
    logic            fire;
    logic            accept;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn <= ssfw_pkg::WarnReset;
            r_stop <= ssfw_pkg::StopReset;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == ssfw_pkg::RegWarn) begin
                r_warn <= pwdata[15:0];
            end else begin
                r_stop <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == ssfw_pkg::RegStop) ? {16'h0000, r_stop}
                                                   : {16'h0000, r_warn};

    assign s_tready = ctrl.load;
    assign accept   = s_tvalid && s_tready;

    ssfw_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_fire     (fire)
    );

    ssfw_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_fire     (fire),
        .i_accept   (accept),
        .i_tdata    (s_tdata),
        .i_warn     (r_warn),
        .i_stop     (r_stop),
        .i_m_tready (m_tready),
        .o_stat     (stat),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    a_one_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_tready)
        else $error("set taken while another is in work");

    a_noch_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tuser == ssfw_pkg::EV_NOCH || m_tuser == ssfw_pkg::EV_STUCK))
        |-> (m_tlast && m_tdata == 8'h00))
        else $error("event item is not a lone zero byte");

    a_warn_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == ssfw_pkg::EV_WARN)
        |-> (m_tdata == ssfw_pkg::SyncByte && !m_tlast))
        else $error("warning not on sync byte");

endmodule

`default_nettype wire

>>> rtl/core/ssfw_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
// Depends on ssfw_pkg for the control word and status types.
`default_nettype none

module ssfw_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire ssfw_pkg::t_stat i_stat,
    output ssfw_pkg::t_ctrl     o_ctrl,
    output logic                o_fire
);

    typedef enum logic [ssfw_pkg::StepW-1:0] {
        ST_WAIT  = 4'd0,
        ST_CHECK = 4'd1,
        ST_FAIL  = 4'd2,
        ST_SYNC  = 4'd3,
        ST_MASK  = 4'd4,
        ST_LEN   = 4'd5,
        ST_HI    = 4'd6,
        ST_LO    = 4'd7,
        ST_SUM   = 4'd8,
        ST_NOCH  = 4'd9,
        ST_STOP  = 4'd10
    } t_step;

    function automatic ssfw_pkg::t_ctrl rom(input t_step s);
        ssfw_pkg::t_ctrl c;
        c = '{load: 1'b0, upd: 1'b0, emit: 1'b0, src: ssfw_pkg::SRC_ZERO,
              ev: ssfw_pkg::EV_NONE, ev_dyn: 1'b0, last: 1'b0,
              cond: ssfw_pkg::C_NONE, target: ST_WAIT};
        unique case (s)
            ST_WAIT: begin
                c.load   = 1'b1;
                c.cond   = ssfw_pkg::C_NOIN;
                c.target = ST_WAIT;
            end
            ST_CHECK: begin
                c.cond   = ssfw_pkg::C_EMPTY;
                c.target = ST_NOCH;
            end
            ST_FAIL: begin
                c.upd    = 1'b1;
                c.cond   = ssfw_pkg::C_STOP;
                c.target = ST_STOP;
            end
            ST_SYNC: begin
                c.emit   = 1'b1;
                c.src    = ssfw_pkg::SRC_SYNC;
                c.ev_dyn = 1'b1;
            end
            ST_MASK: begin
                c.emit = 1'b1;
                c.src  = ssfw_pkg::SRC_MASK;
            end
            ST_LEN: begin
                c.emit = 1'b1;
                c.src  = ssfw_pkg::SRC_LEN;
            end
            ST_HI: begin
                c.emit = 1'b1;
                c.src  = ssfw_pkg::SRC_HI;
            end
            ST_LO: begin
                c.emit   = 1'b1;
                c.src    = ssfw_pkg::SRC_LO;
                c.cond   = ssfw_pkg::C_MORE;
                c.target = ST_HI;
            end
            ST_SUM: begin
                c.emit   = 1'b1;
                c.src    = ssfw_pkg::SRC_SUM;
                c.last   = 1'b1;
                c.cond   = ssfw_pkg::C_ALWAYS;
                c.target = ST_WAIT;
            end
            ST_NOCH: begin
                c.emit   = 1'b1;
                c.ev     = ssfw_pkg::EV_NOCH;
                c.last   = 1'b1;
                c.cond   = ssfw_pkg::C_ALWAYS;
                c.target = ST_WAIT;
            end
            ST_STOP: begin
                c.emit   = 1'b1;
                c.ev     = ssfw_pkg::EV_STUCK;
                c.last   = 1'b1;
                c.cond   = ssfw_pkg::C_ALWAYS;
                c.target = ST_WAIT;
            end
            default: begin
                c.cond   = ssfw_pkg::C_ALWAYS;
                c.target = ST_WAIT;
            end
        endcase
        return c;
    endfunction

    t_step r_step;
    t_step n_step;
    logic  take;

    assign o_ctrl = rom(r_step);
    assign o_fire = !o_ctrl.emit || i_stat.out_free;

    always_comb begin
        unique case (o_ctrl.cond)
            ssfw_pkg::C_NONE:   take = 1'b0;
            ssfw_pkg::C_ALWAYS: take = 1'b1;
            ssfw_pkg::C_NOIN:   take = !i_in_valid;
            ssfw_pkg::C_EMPTY:  take = i_stat.empty;
            ssfw_pkg::C_STOP:   take = i_stat.stop;
            ssfw_pkg::C_MORE:   take = i_stat.more;
            default:            take = 1'b1;
        endcase
        if (take) begin
            n_step = t_step'(o_ctrl.target);
        end else begin
            n_step = t_step'(r_step + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_WAIT;
        end else if (o_fire) begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ssfw_dp.sv
// Datapath: sample store, failure counter, checksum and output register.
// Driven by the control word from ssfw_seq; depends on ssfw_pkg.
`default_nettype none

module ssfw_dp #(
    parameter int CHANNELS = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ssfw_pkg::t_ctrl i_ctrl,
    input  wire logic            i_fire,
    input  wire logic            i_accept,
    input  wire logic [143:0]    i_tdata,
    input  wire logic [15:0]     i_warn,
    input  wire logic [15:0]     i_stop,
    input  wire logic            i_m_tready,
    output ssfw_pkg::t_stat      o_stat,
    output logic                 o_m_tvalid,
    output logic [7:0]           o_m_tdata,
    output logic                 o_m_tlast,
    output logic [1:0]           o_m_tuser
);

    localparam int         IdxW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [7:0] ChMask = 8'((1 << CHANNELS) - 1);

    logic [15:0]         r_smp [CHANNELS];
    logic [7:0]          r_mask;
    logic [CHANNELS-1:0] r_rem;
    logic                r_fail;
    logic [7:0]          r_sum;
    logic [15:0]         r_cnt;
    logic                r_warned;
    logic                r_ev0;
    logic                r_out_valid;
    logic [7:0]          r_out_data;
    logic                r_out_last;
    logic [1:0]          r_out_user;

    logic [15:0]  n_cnt;
    logic         stop_hit;
    logic         warn_hit;
    logic [IdxW-1:0] idx;
    logic [3:0]   pop;
    logic [7:0]   len;
    logic [7:0]   byte_val;
    ssfw_pkg::t_ev ev_val;
    logic         out_fire;
    logic         out_free;

    always_comb begin
        idx = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (r_rem[i]) begin
                idx = IdxW'(i);
            end
        end
        pop = '0;
        for (int i = 0; i < 8; i++) begin
            pop = pop + {3'b000, r_mask[i]};
        end
    end

    assign len = {3'b000, pop, 1'b0};

    always_comb begin
        if (!r_fail) begin
            n_cnt = '0;
        end else if (r_cnt == ssfw_pkg::FailSat) begin
            n_cnt = r_cnt;
        end else begin
            n_cnt = r_cnt + 16'd1;
        end
    end

    assign stop_hit = r_fail && (n_cnt >= i_stop);
    assign warn_hit = r_fail && !stop_hit && (n_cnt >= i_warn) && !r_warned;

    always_comb begin
        unique case (i_ctrl.src)
            ssfw_pkg::SRC_ZERO: byte_val = 8'h00;
            ssfw_pkg::SRC_SYNC: byte_val = ssfw_pkg::SyncByte;
            ssfw_pkg::SRC_MASK: byte_val = r_mask;
            ssfw_pkg::SRC_LEN:  byte_val = len;
            ssfw_pkg::SRC_HI:   byte_val = r_smp[idx][15:8];
            ssfw_pkg::SRC_LO:   byte_val = r_smp[idx][7:0];
            ssfw_pkg::SRC_SUM:  byte_val = r_sum;
            default:            byte_val = 8'h00;
        endcase
        if (i_ctrl.ev_dyn) begin
            ev_val = r_ev0 ? ssfw_pkg::EV_WARN : ssfw_pkg::EV_NONE;
        end else begin
            ev_val = i_ctrl.ev;
        end
    end

    assign out_free = !r_out_valid || i_m_tready;
    assign out_fire = i_fire && i_ctrl.emit;

    assign o_stat.empty    = (r_mask == 8'h00);
    assign o_stat.stop     = stop_hit;
    assign o_stat.more     = |(r_rem & (r_rem - 1'b1));
    assign o_stat.out_free = out_free;

    // Hold the sample set and walk its channels
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_mask <= i_tdata[7:0] & ChMask;
            r_rem  <= i_tdata[CHANNELS-1:0];
            r_fail <= (i_tdata[139:136] >= i_tdata[143:140]);
            r_sum  <= 8'h00;
            for (int i = 0; i < CHANNELS; i++) begin
                r_smp[i] <= i_tdata[8 + 16 * i +: 16];
            end
        end else if (out_fire) begin
            if (i_ctrl.src == ssfw_pkg::SRC_MASK || i_ctrl.src == ssfw_pkg::SRC_LEN
                || i_ctrl.src == ssfw_pkg::SRC_HI || i_ctrl.src == ssfw_pkg::SRC_LO) begin
                r_sum <= r_sum ^ byte_val;
            end
            if (i_ctrl.src == ssfw_pkg::SRC_LO) begin
                r_rem <= r_rem & (r_rem - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_warned <= 1'b0;
            r_ev0    <= 1'b0;
        end else if (i_fire && i_ctrl.upd) begin
            r_cnt <= n_cnt;
            r_ev0 <= warn_hit;
            if (!r_fail) begin
                r_warned <= 1'b0;
            end else if (warn_hit) begin
                r_warned <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (out_fire) begin
            r_out_data <= byte_val;
            r_out_last <= i_ctrl.last;
            r_out_user <= ev_val;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

endmodule

`default_nettype wire
